/* hdl/linear_probe_hash_table_assert.svh */
// Assertion macros shared by the hash table RTL.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// The condition implies the consequence in the same cycle.
`define LPHT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The condition implies the consequence in the following cycle.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/lpht_pkg.sv */
// Shared types and constants of the linear probing hash table.
// Used by lpht_mod, lpht_ram and linear_probe_hash_table.
package lpht_pkg;

    localparam int KEY_W    = 31;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    // One table slot as held in memory.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_RESP
    } t_state;

endpackage

/* hdl/linear_probe_hash_table.sv */
// Top level of the open-addressing hash table with linear probing.
// Depends on lpht_pkg, lpht_mod, lpht_ram and linear_probe_hash_table_assert.svh.
//
//   Channel   Direction  Handshake           Payload
//   request   in         i_valid / o_stall   i_kind, i_key
//   result    out        o_valid / i_stall   o_status, o_slot
//
// A request transfers, the remainder unit works through the key four bits per
// cycle, the home slot is picked up and then the table is probed from it;
// the slot memory gives one entry per cycle with registered read data. The
// result is then loaded into the output register, and the next request is
// taken after that. An unused kind skips straight to the result. After
// reset a clearing pass marks every slot empty, and o_stall stays high
// during it. A stalled result waits in the output register while the next
// request is already being worked on.
module linear_probe_hash_table #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [lpht_pkg::KIND_W-1:0]    i_kind,
    input  logic [lpht_pkg::KEY_W-1:0]     i_key,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [lpht_pkg::STATUS_W-1:0]  o_status,
    output logic [lpht_pkg::SLOT_W-1:0]    o_slot
);
    import lpht_pkg::*;

    localparam int SW = $clog2(TABLE_SIZE);
    localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SIZE - 1);

    // Control state.
    t_state r_state;
    t_state n_state;

    // The request being served.
    logic [KIND_W-1:0] r_kind;
    logic [KEY_W-1:0]  r_key;

    // Probe pointers: r_addr is the slot being read, r_chk_addr the slot whose
    // data is on the memory output this cycle, and r_chk_n counts slots checked.
    logic [SW-1:0] r_addr;
    logic [SW-1:0] n_addr;
    logic [SW-1:0] r_chk_addr;
    logic          r_chk_vld;
    logic          n_chk_vld;
    logic [SW-1:0] r_chk_n;
    logic [SW-1:0] n_chk_n;

    // Result held until the output register is free.
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic [SW-1:0]       r_slot;
    logic [SW-1:0]       n_slot;

    // Output register.
    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [SLOT_W-1:0]   r_o_slot;
    logic [SW+3:0]       w_slot_ext;

    logic   w_in_xfer;
    logic   w_out_xfer;
    logic   w_out_load;
    logic   w_kind_ok;
    logic   w_mod_start;
    logic   w_mod_done;
    logic   [SW-1:0] w_home;
    logic   w_we;
    logic   [SW-1:0] w_waddr;
    t_entry w_wdata;
    t_entry w_rdata;
    logic   w_hit;
    logic   w_last;

    // Requests are taken only in the idle state.
    assign o_stall    = (r_state != ST_IDLE);
    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_xfer = r_o_valid && !i_stall;
    assign w_kind_ok  = (i_kind == KIND_INSERT) || (i_kind == KIND_DELETE)
                     || (i_kind == KIND_SEARCH);

    // Insert stops at the first empty slot, delete and search at the first
    // occupied slot that holds the key.
    assign w_hit = (r_kind == KIND_INSERT) ? !w_rdata.valid
                 : (w_rdata.valid && (w_rdata.key == r_key));
    assign w_last = (r_chk_n == LAST_SLOT);
    assign w_out_load = (r_state == ST_RESP) && (!r_o_valid || !i_stall);

    lpht_mod #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_key   (i_key),
        .o_done  (w_mod_done),
        .o_rem   (w_home)
    );

    lpht_ram #(
        .DEPTH(TABLE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_addr == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = w_kind_ok ? ST_HASH : ST_RESP;
                end
            end
            ST_HASH: begin
                if (w_mod_done) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (r_chk_vld && (w_hit || w_last)) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State outputs and datapath next values.
    always_comb begin
        w_mod_start = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_chk_addr;
        w_wdata     = '{valid: 1'b0, key: r_key};
        n_addr      = r_addr;
        n_chk_vld   = 1'b0;
        n_chk_n     = r_chk_n;
        n_status    = r_status;
        n_slot      = r_slot;
        case (r_state)
            ST_CLEAR: begin
                // Sweep every slot to empty, one per cycle.
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = '{valid: 1'b0, key: '0};
                n_addr  = (r_addr == LAST_SLOT) ? '0 : r_addr + 1'b1;
            end
            ST_IDLE: begin
                w_mod_start = w_in_xfer && w_kind_ok;
                if (w_in_xfer && !w_kind_ok) begin
                    n_status = STATUS_MISSING;
                    n_slot   = '0;
                end
            end
            ST_HASH: begin
                if (w_mod_done) begin
                    n_addr  = w_home;
                    n_chk_n = '0;
                end
            end
            ST_PROBE: begin
                // Reads run one slot ahead of the check; extra reads are harmless.
                n_addr    = (r_addr == LAST_SLOT) ? '0 : r_addr + 1'b1;
                n_chk_vld = 1'b1;
                if (r_chk_vld) begin
                    if (w_hit) begin
                        w_we     = (r_kind != KIND_SEARCH);
                        w_wdata  = '{valid: (r_kind == KIND_INSERT), key: r_key};
                        n_status = STATUS_OK;
                        n_slot   = r_chk_addr;
                    end else if (w_last) begin
                        n_status = (r_kind == KIND_INSERT) ? STATUS_FULL : STATUS_MISSING;
                        n_slot   = '0;
                    end else begin
                        n_chk_n = r_chk_n + 1'b1;
                    end
                end
            end
            ST_RESP: begin
                n_addr = r_addr;
            end
            default: begin
                n_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_chk_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_chk_vld <= n_chk_vld;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign w_slot_ext = {4'b0000, r_slot};

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_kind <= i_kind;
            r_key  <= i_key;
        end
        r_chk_addr <= r_addr;
        r_chk_n    <= n_chk_n;
        r_status   <= n_status;
        r_slot     <= n_slot;
        if (w_out_load) begin
            r_o_status <= r_status;
            r_o_slot   <= w_slot_ext[3:0];
        end
    end

    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_slot   = r_o_slot;

`include "linear_probe_hash_table_assert.svh"

    `LPHT_ASSERT_SAME(a_no_write_idle, r_state == ST_IDLE, !w_we, "slot write while idle")
    `LPHT_ASSERT_SAME(a_fail_slot_zero,
        o_valid && (o_status != STATUS_OK),
        o_slot == 4'd0, "nonzero slot on failure")
    `LPHT_ASSERT_NEXT(a_accept_starts, w_in_xfer,
        r_state == ST_HASH || r_state == ST_RESP,
        "accepted request not started")
    `LPHT_ASSERT_SAME(a_mod_done_hash, w_mod_done, r_state == ST_HASH,
        "home slot outside hash phase")

endmodule

/* hdl/lpht_mod.sv */
// Multi-cycle remainder unit: key modulo TABLE_SIZE, four key bits per cycle.
// Depends on lpht_pkg.
module lpht_mod #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lpht_pkg::KEY_W-1:0]    i_key,
    output logic                          o_done,
    output logic [$clog2(TABLE_SIZE)-1:0] o_rem
);
    import lpht_pkg::*;

    localparam int RW   = $clog2(TABLE_SIZE);
    localparam int STEP = 4;
    localparam int NDIG = (KEY_W + STEP - 1) / STEP;
    localparam int PAD  = NDIG * STEP;
    localparam int CW   = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam logic [RW:0]   TS_W   = (RW+1)'(TABLE_SIZE);
    localparam logic [CW-1:0] LAST_D = CW'(NDIG - 1);

    logic [PAD-1:0] r_sh;
    logic [RW-1:0]  r_rem;
    logic [RW-1:0]  n_rem;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    // Restoring remainder: shift in one bit, subtract the modulus once if reached.
    always_comb begin
        logic [RW:0] t;
        n_rem = r_rem;
        for (int j = 0; j < STEP; j++) begin
            t = {n_rem, r_sh[PAD-1-j]};
            if (t >= TS_W) begin
                t = t - TS_W;
            end
            n_rem = t[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_D) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= {{(PAD-KEY_W){1'b0}}, i_key};
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= r_sh << STEP;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* hdl/lpht_ram.sv */
// Slot memory: one write port, one read port with registered read data.
// Depends on lpht_pkg for the entry type.
module lpht_ram #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  lpht_pkg::t_entry         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output lpht_pkg::t_entry         o_rdata
);
    import lpht_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* bench/linear_probe_hash_table_test.sv */
// Self-checking testbench for linear_probe_hash_table: insert, delete and search requests.
// Results are predicted by a slot-level model in the bench and checked in order.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
module linear_probe_hash_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    localparam int SLOTS        = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = SLOTS + 24;
    localparam int HOLDOFF_LEN  = 400;

    // Kind value 3 has no operation. The block must answer it with key not found
    // and leave the table as it was.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } t_lookup_result;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [KIND_W-1:0]   i_kind  = '0;
    logic [KEY_W-1:0]    i_key   = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot;

    // The bench's own copy of the table. A deleted slot keeps its key, only
    // the occupancy bit is cleared.
    logic [KEY_W-1:0] bucket_key [SLOTS];
    logic             bucket_used [SLOTS];

    // Results still owed by the block, oldest first.
    t_lookup_result pending_results [$];
    t_lookup_result head_result;

    int fail_count  = 0;
    int cycle_count = 0;

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;

    // A long receiver hold-off is requested by bumping holdoff_asks. The stall
    // process counts it down on its own.
    int holdoff_asks = 0;
    int holdoff_done = 0;
    int holdoff_left = 0;

    linear_probe_hash_table #(
        .TABLE_SIZE(SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_kind  (i_kind),
        .i_key   (i_key),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_status(o_status),
        .o_slot  (o_slot)
    );

    // 4 ns clock period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one request to the bench table and returns the result the block
    // owes for it. The home slot is the key modulo the table size, and probing
    // steps by one slot with wraparound.
    function automatic t_lookup_result apply_request(input logic [KIND_W-1:0] kind,
                                                     input logic [KEY_W-1:0] key);
        t_lookup_result res;
        int home;
        int s;
        res.status = STATUS_MISSING;
        res.slot   = '0;
        home = int'(key % SLOTS);
        if (kind == KIND_INSERT) begin
            // Insert takes the first empty slot, so duplicate keys are allowed.
            res.status = STATUS_FULL;
            for (int n = 0; n < SLOTS; n++) begin
                s = (home + n) % SLOTS;
                if (!bucket_used[s]) begin
                    bucket_key[s]  = key;
                    bucket_used[s] = 1'b1;
                    res.status     = STATUS_OK;
                    res.slot       = SLOT_W'(s);
                    break;
                end
            end
        end else if (kind == KIND_DELETE || kind == KIND_SEARCH) begin
            // Every slot is visited once; the first occupied match wins.
            for (int n = 0; n < SLOTS; n++) begin
                s = (home + n) % SLOTS;
                if (bucket_used[s] && bucket_key[s] == key) begin
                    if (kind == KIND_DELETE) begin
                        bucket_used[s] = 1'b0;
                    end
                    res.status = STATUS_OK;
                    res.slot   = SLOT_W'(s);
                    break;
                end
            end
        end
        return res;
    endfunction

    // Keys are drawn so that home slots collide often and stored keys are hit
    // by delete and search, with fully random keys and keys near the top of
    // the range mixed in.
    function automatic logic [KEY_W-1:0] pick_key();
        int s;
        s = $urandom_range(SLOTS - 1);
        case ($urandom_range(3))
            0: return KEY_W'($urandom);
            1: return KEY_W'($urandom_range(0, 47));
            2: begin
                if (bucket_used[s]) begin
                    return bucket_key[s];
                end
                return KEY_W'($urandom_range(0, 3) * SLOTS + s);
            end
            default: return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 47));
        endcase
    endfunction

    // Sends one request. The task is entered and left at a falling edge, and
    // i_valid is left high so that back-to-back requests never drop it.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_key   <= key;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        // The transfer happened at this edge, so the request is now owed a result.
        pending_results.push_back(apply_request(kind, key));
        @(negedge i_clk);
    endtask

    // Sends a run of random requests. The weights set the share of inserts,
    // deletes and searches; the unused kind gets a small fixed share.
    task automatic send_random(input int count, input int ins_w, input int del_w,
                               input int srch_w);
        int pick;
        logic [KIND_W-1:0] kind;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, ins_w + del_w + srch_w + 3);
            if (pick < ins_w) begin
                kind = KIND_INSERT;
            end else if (pick < ins_w + del_w) begin
                kind = KIND_DELETE;
            end else if (pick < ins_w + del_w + srch_w) begin
                kind = KIND_SEARCH;
            end else begin
                kind = KIND_UNUSED;
            end
            send_request(kind, pick_key());
        end
    endtask

    // Hand-picked requests: both key extremes, every kind, collisions that wrap
    // past the last slot, duplicates, a delete and a search that miss, the
    // unused kind, and then a table filled up until an insert finds it full.
    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_request(KIND_INSERT, '0);
        send_request(KIND_INSERT, KEY_W'(SLOTS));
        send_request(KIND_INSERT, {KEY_W{1'b1}});
        // Home slot is the last one and taken, so the probe wraps to the start.
        send_request(KIND_INSERT, KEY_W'(SLOTS - 1));
        send_request(KIND_INSERT, '0);
        send_request(KIND_DELETE, '0);
        // The duplicate further along the probe chain must now be found.
        send_request(KIND_SEARCH, '0);
        send_request(KIND_DELETE, '0);
        send_request(KIND_DELETE, '0);
        send_request(KIND_UNUSED, {KEY_W{1'b1}});
        send_request(KIND_SEARCH, {KEY_W{1'b1}});
        // Thirteen slots are free now; fill them all with keys of one home slot.
        for (int i = 0; i < SLOTS - 3; i++) begin
            send_request(KIND_INSERT, KEY_W'(5 + SLOTS * (i + 1)));
        end
        send_request(KIND_INSERT, KEY_W'(7));
        // A miss in a full table probes every slot once.
        send_request(KIND_SEARCH, KEY_W'(3));
    endtask

    // The bulk of the traffic, with both sides idling at random.
    task automatic test_random_mix();
        idle_pct  = 34;
        stall_pct = 34;
        send_random(500, 40, 30, 30);
    endtask

    // A long stretch where neither side ever idles.
    task automatic test_no_idle_stretch();
        idle_pct  = 0;
        stall_pct = 0;
        send_random(200, 40, 30, 30);
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the output register fills and the block stalls its input.
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        holdoff_asks++;
        send_random(40, 40, 30, 30);
        idle_pct  = 34;
        stall_pct = 34;
        send_random(60, 40, 30, 30);
    endtask

    // Alternating phases push the table to full and back to nearly empty.
    task automatic test_fill_and_drain();
        idle_pct  = 34;
        stall_pct = 34;
        for (int round = 0; round < 3; round++) begin
            send_random(60, 80, 10, 10);
            send_random(60, 10, 70, 20);
        end
    endtask

    // Receiver side: a random stall each cycle, or a counted hold-off.
    always @(negedge i_clk) begin
        if (holdoff_asks != holdoff_done) begin
            holdoff_done = holdoff_asks;
            holdoff_left = HOLDOFF_LEN;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Each result transfer is matched against the oldest outstanding request.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding: status %0d slot %0d",
                       o_status, o_slot);
                fail_count++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_status !== head_result.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           head_result.status, o_status);
                    fail_count++;
                end
                if (o_slot !== head_result.slot) begin
                    $error("slot mismatch: expected %0d, actual %0d",
                           head_result.slot, o_slot);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            bucket_key[i]  = '0;
            bucket_used[i] = 1'b0;
        end
        // Reset is held first and released at a falling edge. The clearing pass that follows
        // keeps o_stall high, which send_request simply waits out.
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_mix();
        test_no_idle_stretch();
        test_backpressure();
        test_fill_and_drain();

        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        // Give a stray extra result time to show up before judging the run.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
